@@ hw/rtl/acc_pkg.sv @@
// Package for the autofire click controller: payload structs, codes, widths.
// No dependencies.
package acc_pkg;
	localparam int TimeW   = 32;
	localparam int RepW    = 16;
	localparam int RateW   = 14;
	localparam int DivW    = 16;
	localparam logic [13:0] RateScale = 14'd10000;
	// above this effective interval the rounded rate is zero
	localparam int EffMax  = 2 * 10000;

	localparam logic [1:0] FUNC_TICK = 2'd0;
	localparam logic [1:0] FUNC_KEY  = 2'd1;
	localparam logic [1:0] FUNC_RATE = 2'd2;

	localparam logic [1:0] KEY_LEFT  = 2'd0;
	localparam logic [1:0] KEY_RIGHT = 2'd1;
	localparam logic [1:0] KEY_OK    = 2'd2;

	localparam logic [1:0] KIND_SHORT   = 2'd0;
	localparam logic [1:0] KIND_LONG    = 2'd1;
	localparam logic [1:0] KIND_REPEAT  = 2'd2;
	localparam logic [1:0] KIND_RELEASE = 2'd3;

	localparam logic [1:0] EV_NONE    = 2'd0;
	localparam logic [1:0] EV_PRESS   = 2'd1;
	localparam logic [1:0] EV_RELEASE = 2'd2;

	localparam logic [2:0] REG_FLOOR   = 3'd0;
	localparam logic [2:0] REG_CEIL    = 3'd1;
	localparam logic [2:0] REG_SMALL   = 3'd2;
	localparam logic [2:0] REG_MEDIUM  = 3'd3;
	localparam logic [2:0] REG_FAST    = 3'd4;
	localparam logic [2:0] REG_MED_TH  = 3'd5;
	localparam logic [2:0] REG_FAST_TH = 3'd6;

	typedef struct packed {
		logic [1:0] func;
		logic [1:0] key;
		logic [1:0] press_kind;
	} in_item_t;

	typedef struct packed {
		logic       button_down;
		logic [1:0] report_event;
		logic       running;
		logic [9:0] delay_now;
		logic [13:0] rate_x10;
	} out_item_t;

	typedef struct packed {
		logic [9:0]  delay_floor;
		logic [9:0]  delay_ceiling;
		logic [9:0]  step_small;
		logic [9:0]  step_medium;
		logic [9:0]  step_fast;
		logic [15:0] medium_threshold;
		logic [15:0] fast_threshold;
	} cfg_t;
endpackage

@@ hw/rtl/autofire_click_controller_top.sv @@
// Top level of the autofire click controller: front queue, back executor.
// Depends on acc_pkg, acc_front, acc_back.
//
// Input channel: push/full, one item per beat (tick, key event, rate refresh).
// Result channel: empty/pop, exactly one result per item, in order.
// Config channel: cfg_valid/cfg_ready, always ready; write only while idle.
// A tick or key item's result is registered as the back part takes the item.
// A rate refresh runs a bit-serial divider through the DIV and WAIT states;
// its result is registered once the divider is no longer busy.
// The back part takes a new item only when idle and its last result popped;
// the two-beat front queue absorbs short bursts.
// Reset sets control state and config to defaults (queue storage and the divisor latch excepted); no clearing pass.
// When the receiver stalls, the back part holds its result and stops taking
// items; the front queue fills and full rises.
module autofire_click_controller_top import acc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  in_item_t   in_item,
	output logic       empty,
	input  logic       pop,
	output out_item_t  out_item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data
);
	cfg_t     cfg;
	logic     q_valid, q_take;
	in_item_t q_item;

	acc_front u_front (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .item(in_item),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .cfg(cfg), .q_valid(q_valid), .q_item(q_item),
		.q_take(q_take)
	);

	acc_back u_back (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .q_valid(q_valid), .q_item(q_item),
		.q_take(q_take), .empty(empty), .pop(pop), .result(out_item)
	);
endmodule

@@ hw/rtl/acc_front.sv @@
// Front part: input queue of two beats plus the configuration register file.
// Depends on acc_pkg.
module acc_front import acc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  in_item_t   item,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic [2:0] cfg_index,
	input  logic [15:0] cfg_data,
	output cfg_t       cfg,
	output logic       q_valid,
	output in_item_t   q_item,
	input  logic       q_take
);
	in_item_t   mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;
	logic       wr, rd;

	assign full      = cnt_q[1];
	assign wr        = push && !full;
	assign q_valid   = cnt_q != 2'd0;
	assign rd        = q_take && q_valid;
	assign q_item    = mem_q[rp_q];
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= item;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0; rp_q <= 1'b0; cnt_q <= 2'd0;
		end else begin
			if (wr) wp_q <= !wp_q;
			if (rd) rp_q <= !rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg <= '{10'd5, 10'd1000, 10'd10, 10'd50, 10'd100, 16'd3, 16'd8};
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_FLOOR:   cfg.delay_floor      <= cfg_data[9:0];
				REG_CEIL:    cfg.delay_ceiling    <= cfg_data[9:0];
				REG_SMALL:   cfg.step_small       <= cfg_data[9:0];
				REG_MEDIUM:  cfg.step_medium      <= cfg_data[9:0];
				REG_FAST:    cfg.step_fast        <= cfg_data[9:0];
				REG_MED_TH:  cfg.medium_threshold <= cfg_data;
				REG_FAST_TH: cfg.fast_threshold   <= cfg_data;
				default: ;
			endcase
		end
	end
endmodule

@@ hw/rtl/acc_div.sv @@
// Restoring divider, one quotient bit per cycle, for the rate computation.
// Depends on acc_pkg.
module acc_div import acc_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	input  logic [DivW-1:0] num,
	input  logic [TimeW-1:0] den,
	output logic            busy,
	output logic [DivW-1:0] quo
);
	logic [DivW-1:0]  rem_q;
	logic [4:0]       cnt_q;
	logic [TimeW:0]   trial;
	logic [TimeW:0]   shifted;

	assign busy    = cnt_q != 5'd0;
	assign shifted = {{(TimeW+1-DivW){1'b0}}, rem_q} << 1 | {{TimeW{1'b0}}, quo[DivW-1]};
	assign trial   = shifted - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= 5'd0; rem_q <= '0; quo <= '0;
		end else if (start) begin
			cnt_q <= 5'(DivW); rem_q <= '0; quo <= num;
		end else if (busy) begin
			cnt_q <= cnt_q - 5'd1;
			if (!trial[TimeW]) begin
				rem_q <= trial[DivW-1:0];
				quo   <= {quo[DivW-2:0], 1'b1};
			end else begin
				rem_q <= shifted[DivW-1:0];
				quo   <= {quo[DivW-2:0], 1'b0};
			end
		end
	end
endmodule

@@ hw/rtl/acc_back.sv @@
// Back part: executes one queued item at a time and fills the result queue.
// Depends on acc_pkg and acc_div.
module acc_back import acc_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      q_valid,
	input  in_item_t  q_item,
	output logic      q_take,
	output logic      empty,
	input  logic      pop,
	output out_item_t result
);
	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_DIV  = 2'd1;
	localparam logic [1:0] ST_WAIT = 2'd2;

	logic [1:0]       st_q;
	logic [TimeW-1:0] time_q, last_rel_q, interval_q;
	logic [9:0]       cd_q, delay_q;
	logic             active_q, phase_q, level_q, hold_q, hkey_q, seen_q;
	logic [RepW-1:0]  rep_q;
	logic [RateW-1:0] rate_q;
	logic             out_v_q;
	logic             div_start, div_busy;
	logic [DivW-1:0]  div_quo;
	logic [TimeW-1:0] eff_q;

	// combinational next state
	logic [TimeW-1:0] time_n, last_rel_n, interval_n;
	logic [9:0]       cd_n, delay_n, half_d, half_n, step, dcl, nd;
	logic             active_n, phase_n, level_n, hold_n, hkey_n, seen_n;
	logic [RepW-1:0]  rep_n;
	logic [RateW-1:0] rate_n;
	logic [1:0]       ev;
	logic             go, do_adj, rate_zero, adj_dn;
	logic [TimeW-1:0] elapsed, iv, eff;

	assign empty  = !out_v_q;
	assign go     = st_q == ST_IDLE && q_valid && !out_v_q;
	assign q_take = go;
	assign div_start = go && q_item.func == FUNC_RATE && !rate_zero;

	function automatic logic [9:0] halfof(input logic [9:0] d);
		return (d[9:1] == 9'd0) ? 10'd1 : {1'b0, d[9:1]};
	endfunction

	always_comb begin
		time_n = time_q; last_rel_n = last_rel_q; interval_n = interval_q;
		cd_n = cd_q; delay_n = delay_q; active_n = active_q; phase_n = phase_q;
		level_n = level_q; hold_n = hold_q; hkey_n = hkey_q; seen_n = seen_q;
		rep_n = rep_q; rate_n = rate_q; ev = EV_NONE; do_adj = 1'b0;
		adj_dn = q_item.key == KEY_LEFT; step = cfg.step_small;
		half_d = halfof(delay_q);
		elapsed = time_q - last_rel_q;
		eff = (elapsed > interval_q) ? elapsed : interval_q;
		if (eff == '0) eff = {{(TimeW-1){1'b0}}, 1'b1};
		// long intervals round to zero and would overflow the dividend
		rate_zero = !active_q || !seen_q || interval_q == '0 || eff > TimeW'(EffMax);
		iv = '0; dcl = '0; nd = '0; half_n = '0;
		unique case (q_item.func)
			FUNC_TICK: begin
				time_n = time_q + 1'b1;
				if (active_q) begin
					if (cd_q <= 10'd1) begin
						cd_n = half_d;
						if (!phase_q) begin
							level_n = 1'b1; phase_n = 1'b1; ev = EV_PRESS;
						end else begin
							level_n = 1'b0; phase_n = 1'b0; ev = EV_RELEASE;
							iv = time_n - last_rel_q;
							if (seen_q) interval_n = (iv == '0) ? TimeW'(1) : iv;
							last_rel_n = time_n; seen_n = 1'b1;
						end
					end else cd_n = cd_q - 10'd1;
				end
			end
			FUNC_KEY: begin
				if (q_item.key == KEY_LEFT || q_item.key == KEY_RIGHT) begin
					case (q_item.press_kind)
						KIND_SHORT: do_adj = 1'b1;
						KIND_LONG: begin
							hold_n = 1'b1; hkey_n = q_item.key[0]; rep_n = '0;
							step = cfg.step_medium; do_adj = 1'b1;
						end
						KIND_REPEAT: begin
							rep_n = (!hold_q || hkey_q != q_item.key[0]) ? '0 : rep_q;
							hold_n = 1'b1; hkey_n = q_item.key[0];
							if (rep_n != '1) rep_n = rep_n + 1'b1;
							if (rep_n >= cfg.fast_threshold) step = cfg.step_fast;
							else if (rep_n >= cfg.medium_threshold) step = cfg.step_medium;
							do_adj = 1'b1;
						end
						default: if (hold_q && hkey_q == q_item.key[0]) begin
							hold_n = 1'b0; hkey_n = 1'b0; rep_n = '0;
						end
					endcase
				end else if (q_item.key == KEY_OK && q_item.press_kind == KIND_RELEASE) begin
					rate_n = '0; seen_n = 1'b0; last_rel_n = '0;
					interval_n = {{(TimeW-11){1'b0}}, half_d, 1'b0};
					phase_n = 1'b0;
					if (active_q) begin
						active_n = 1'b0; cd_n = '0;
						if (level_q) begin level_n = 1'b0; ev = EV_RELEASE; end
						hold_n = 1'b0; hkey_n = 1'b0; rep_n = '0;
					end else begin
						active_n = 1'b1; level_n = 1'b1; phase_n = 1'b1;
						ev = EV_PRESS; cd_n = half_d;
					end
				end
			end
			FUNC_RATE: if (rate_zero) rate_n = '0;
			default: ;
		endcase
		if (do_adj) begin
			dcl = (delay_q < cfg.delay_floor) ? cfg.delay_floor :
				(delay_q > cfg.delay_ceiling) ? cfg.delay_ceiling : delay_q;
			if (step == '0) nd = dcl;
			else if (adj_dn) nd = (dcl <= cfg.delay_floor || dcl - cfg.delay_floor < step)
				? cfg.delay_floor : dcl - step;
			else nd = (dcl >= cfg.delay_ceiling || cfg.delay_ceiling - dcl < step)
				? cfg.delay_ceiling : dcl + step;
			nd = (nd < cfg.delay_floor) ? cfg.delay_floor :
				(nd > cfg.delay_ceiling) ? cfg.delay_ceiling : nd;
			half_n = halfof(nd);
			if (nd != delay_q) begin
				delay_n = nd;
				if (active_q) cd_n = half_n;
			end
		end
	end

	acc_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num({{(DivW-14){1'b0}}, RateScale} + DivW'(eff >> 1)),
		.den(eff_q), .busy(div_busy), .quo(div_quo)
	);

	always_ff @(posedge clk) begin
		if (div_start) eff_q <= eff;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; out_v_q <= 1'b0;
			time_q <= '0; last_rel_q <= '0; interval_q <= TimeW'(10);
			cd_q <= '0; delay_q <= 10'd10; active_q <= 1'b0; phase_q <= 1'b0;
			level_q <= 1'b0; hold_q <= 1'b0; hkey_q <= 1'b0; seen_q <= 1'b0;
			rep_q <= '0; rate_q <= '0; result <= '0;
		end else begin
			if (pop && out_v_q) out_v_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (go) begin
					time_q <= time_n; last_rel_q <= last_rel_n; interval_q <= interval_n;
					cd_q <= cd_n; delay_q <= delay_n; active_q <= active_n;
					phase_q <= phase_n; level_q <= level_n; hold_q <= hold_n;
					hkey_q <= hkey_n; seen_q <= seen_n; rep_q <= rep_n; rate_q <= rate_n;
					if (div_start) st_q <= ST_DIV;
					else begin
						result <= '{level_n, ev, active_n, delay_n, rate_n};
						out_v_q <= 1'b1;
					end
				end
				ST_DIV: st_q <= ST_WAIT;
				ST_WAIT: if (!div_busy) begin
					rate_q <= div_quo[RateW-1:0];
					result <= '{level_q, EV_NONE, active_q, delay_q, div_quo[RateW-1:0]};
					out_v_q <= 1'b1; st_q <= ST_IDLE;
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end
endmodule

@@ hw/rtl/acc_checker.sv @@
// Port-level checker for the autofire click controller, bound to the top.
// Depends on acc_pkg.
module acc_checker import acc_pkg::*; (
	input logic      clk,
	input logic      arst_n,
	input logic      empty,
	input logic      pop,
	input out_item_t out_item
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(out_item)) else $error("result moved");
	a_ev: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_item.report_event == EV_PRESS |-> out_item.button_down)
		else $error("press with button up");
	a_rel: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && out_item.report_event == EV_RELEASE |-> !out_item.button_down)
		else $error("release with button down");
	a_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !out_item.running |-> out_item.rate_x10 == '0)
		else $error("rate while stopped");
endmodule

bind autofire_click_controller_top acc_checker u_chk (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.out_item(out_item)
);
